/* hw/rtl/cmdv_pkg.sv */
// package for the command line parser and validator
// holds the phase and sequencer types, register indexes, status codes and the name table
package cmdv_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_WORD   = 3'd1,
        PH_NUMBER = 3'd2,
        PH_BLANK  = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_LO,
        ST_SCAN_HI,
        ST_DIG_RD,
        ST_DIG_WR,
        ST_NL_RD,
        ST_NL_CAP,
        ST_NL_OUT
    } seq_state_t;

    localparam logic [7:0] REG_FREQ_LOW  = 8'd0;
    localparam logic [7:0] REG_FREQ_HIGH = 8'd1;
    localparam logic [7:0] REG_TIME_MAX  = 8'd2;
    localparam logic [7:0] REG_MIN_SPAN  = 8'd3;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_SYNTAX  = 3'd1;
    localparam logic [2:0] STS_MISSING = 3'd2;
    localparam logic [2:0] STS_EXTRA   = 3'd3;
    localparam logic [2:0] STS_TIME    = 3'd4;
    localparam logic [2:0] STS_FREQ    = 3'd5;
    localparam logic [2:0] STS_SPAN    = 3'd6;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_SWEEP  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_SETF   = 3'd3;
    localparam logic [2:0] ACT_REPF   = 3'd4;
    localparam logic [2:0] ACT_ID     = 3'd5;
    localparam logic [2:0] ACT_STATE  = 3'd6;
    localparam logic [2:0] ACT_MODE   = 3'd7;

    localparam logic [4:0] ROW_APAGAR  = 5'd0;
    localparam logic [4:0] ROW_BARRER  = 5'd1;
    localparam logic [4:0] ROW_CFT     = 5'd2;
    localparam logic [4:0] ROW_CPDIS   = 5'd3;
    localparam logic [4:0] ROW_CPSNK   = 5'd4;
    localparam logic [4:0] ROW_CPSRC   = 5'd5;
    localparam logic [4:0] ROW_ESTADO  = 5'd6;
    localparam logic [4:0] ROW_FREC    = 5'd7;
    localparam logic [4:0] ROW_FRECU   = 5'd8;
    localparam logic [4:0] ROW_FRECUQ  = 5'd9;
    localparam logic [4:0] ROW_FRECQ   = 5'd10;
    localparam logic [4:0] ROW_IDQ     = 5'd11;
    localparam logic [4:0] ROW_INICIAR = 5'd12;
    localparam logic [4:0] ROW_STOP    = 5'd14;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUEST = 8'd63;

    function automatic logic [7:0] name_char(input logic [4:0] row, input logic [3:0] pos);
        logic [127:0] s;
        s = '0;
        unique case (row)
            5'd0:    s = {"apagar", 80'h0};
            5'd1:    s = {"barrer", 80'h0};
            5'd2:    s = {"cft", 104'h0};
            5'd3:    s = {"cpdis", 88'h0};
            5'd4:    s = {"cpsnk", 88'h0};
            5'd5:    s = {"cpsrc", 88'h0};
            5'd6:    s = {"estado", 80'h0};
            5'd7:    s = {"frec", 96'h0};
            5'd8:    s = {"frecuencia", 48'h0};
            5'd9:    s = {"frecuencia?", 40'h0};
            5'd10:   s = {"frec?", 88'h0};
            5'd11:   s = {"id?", 104'h0};
            5'd12:   s = {"iniciar", 72'h0};
            5'd13:   s = {"reset", 88'h0};
            5'd14:   s = {"stop", 96'h0};
            5'd15:   s = {"test", 96'h0};
            default: s = '0;
        endcase
        return s[127 - 8 * pos -: 8];
    endfunction

endpackage

/* hw/rtl/command_line_parser_validator.sv */
// command line parser and validator: one character per beat, one result beat per newline
// a plain character is taken in the idle state; a letter scans the name table (one table row a
// cycle) while the window is open, and is taken without a scan once it is empty; a digit reads,
// then writes its ram entry; a newline reads up to three ram slots, then waits for any previous result beat
// reset is asynchronous and active low; accumulator ram entries read as zero until written
// uses cmdv_pkg and cmdv_ram
module command_line_parser_validator
    import cmdv_pkg::*;
#(
    parameter int NUM_COMMANDS = 16,
    parameter int MAX_PARAMS   = 3,
    parameter int NAME_LENGTH  = 12,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status, command_index, action, mode_value,
                                   // param_first, param_second, param_third
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int RW    = $clog2(NUM_COMMANDS);
    localparam int NROWS = NUM_COMMANDS > 32 ? 32 : NUM_COMMANDS;
    localparam int POS_W = $clog2(NAME_LENGTH + 1);
    localparam int CNT_W = $clog2(MAX_PARAMS + 2);
    localparam int AW    = MAX_PARAMS > 1 ? $clog2(MAX_PARAMS) : 1;
    localparam int NP    = MAX_PARAMS < 3 ? MAX_PARAMS : 3;
    localparam int VW    = VALUE_WIDTH;
    localparam int CW    = (VW > 16 ? VW : 16) + 1;
    localparam logic signed [RW:0] LAST_ROW = (RW + 1)'(NROWS - 1);
    localparam logic [VW-1:0] MAXV = {VW{1'b1}};

    seq_state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [RW-1:0] first_reg, first_next, row_reg, row_next;
    logic signed [RW:0] last_reg, last_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAX_PARAMS-1:0] avld_reg, avld_next;
    logic [7:0] chr_reg, chr_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [1:0] k_reg, k_next;
    logic [VW-1:0] p_reg [3];
    logic [VW-1:0] p_next [3];
    logic [15:0] flo_reg, fhi_reg, tmax_reg, span_reg;
    logic out_vld_reg, out_vld_next;
    logic [63:0] out_reg, out_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_wdata, ram_rdata;

    cmdv_ram #(.WIDTH(VW), .DEPTH(MAX_PARAMS)) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [7:0] c, lc;
    logic is_alpha, is_digit, is_blank, is_nl, win_open, acc_beat;
    logic [7:0] tch, tch_first;
    logic [VW-1:0] cur_val;
    logic [VW+3:0] mac;
    logic found;
    logic [2:0] need, j_status, j_action, j_mode;
    logic signed [RW+1:0] row_s;

    function automatic logic [7:0] tchar(input logic [RW-1:0] row, input logic [POS_W-1:0] pos);
        if (32'(pos) >= NAME_LENGTH)
            return 8'd0;
        return name_char(5'(row), 4'(pos));
    endfunction

    function automatic logic in_band(input logic [VW-1:0] f, input logic [15:0] lo,
                                     input logic [15:0] hi);
        return (CW'(f) >= CW'(lo)) && (CW'(f) <= CW'(hi));
    endfunction

    assign c        = s_tdata;
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit = c >= "0" && c <= "9";
    assign is_blank = c == CH_SPACE || c == CH_TAB;
    assign is_nl    = c == CH_NL;
    assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign win_open = last_reg >= $signed({1'b0, first_reg});
    assign s_tready = state_reg == ST_IDLE;
    assign acc_beat = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
    assign tch       = tchar(row_reg, pos_reg);
    assign tch_first = tchar(first_reg, pos_reg);
    assign cur_val  = avld_reg[slot_reg] ? ram_rdata : '0;
    assign mac      = (VW + 4)'(cur_val) * (VW + 4)'(10) + (VW + 4)'(chr_reg - "0");
    assign row_s    = $signed({2'b00, row_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_beat)
                begin
                    if (is_nl)
                        state_next = ST_NL_RD;
                    else if (phase_reg == PH_START && is_alpha && win_open)
                        state_next = ST_SCAN_LO;
                    else if (phase_reg == PH_WORD && c != CH_SPACE
                             && (is_alpha || is_digit || c == CH_QUEST) && win_open)
                        state_next = ST_SCAN_LO;
                    else if (phase_reg == PH_NUMBER && is_digit && cnt_reg >= 1
                             && 32'(cnt_reg) - 1 < MAX_PARAMS)
                        state_next = ST_DIG_RD;
                    else if (phase_reg == PH_BLANK && is_digit && 32'(cnt_reg) < MAX_PARAMS)
                        state_next = ST_DIG_RD;
                end
            end
            ST_SCAN_LO:
            begin
                if (tch == chr_reg || row_s[RW:0] == last_reg)
                    state_next = ST_SCAN_HI;
            end
            ST_SCAN_HI:
            begin
                if (tch != chr_reg || row_s[RW:0] == last_reg)
                    state_next = ST_IDLE;
            end
            ST_DIG_RD: state_next = ST_DIG_WR;
            ST_DIG_WR: state_next = ST_IDLE;
            ST_NL_RD:  state_next = ST_NL_CAP;
            ST_NL_CAP: state_next = (32'(k_reg) + 1 >= NP) ? ST_NL_OUT : ST_NL_RD;
            ST_NL_OUT: state_next = out_vld_reg ? ST_NL_OUT : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // line judgment
    always_comb
    begin
        found    = win_open && tch_first == 8'd0;
        need     = (5'(first_reg) == ROW_BARRER) ? 3'd3 : (5'(first_reg) == ROW_FREC) ? 3'd1 : 3'd0;
        j_status = STS_OK;
        j_action = ACT_NONE;
        j_mode   = 3'd0;
        if (!found)
            j_status = STS_SYNTAX;
        else if (CNT_W'(need) > cnt_reg)
            j_status = STS_MISSING;
        else if (CNT_W'(need) < cnt_reg)
            j_status = STS_EXTRA;
        else
        begin
            unique case (5'(first_reg))
                ROW_BARRER:
                begin
                    if (p_reg[0] == '0 || CW'(p_reg[0]) > CW'(tmax_reg))
                        j_status = STS_TIME;
                    else if (!in_band(p_reg[1], flo_reg, fhi_reg)
                             || !in_band(p_reg[2], flo_reg, fhi_reg))
                        j_status = STS_FREQ;
                    else if (CW'(p_reg[1]) >= CW'(p_reg[2]) + CW'(span_reg))
                        j_status = STS_SPAN;
                    else
                        j_action = ACT_SWEEP;
                end
                ROW_STOP: j_action = ACT_STOP;
                ROW_FREC, ROW_FRECU:
                begin
                    if (in_band(p_reg[0], flo_reg, fhi_reg))
                        j_action = ACT_SETF;
                    else
                        j_status = STS_FREQ;
                end
                ROW_FRECUQ, ROW_FRECQ: j_action = ACT_REPF;
                ROW_IDQ:     j_action = ACT_ID;
                ROW_ESTADO:  j_action = ACT_STATE;
                ROW_CFT:     begin j_action = ACT_MODE; j_mode = 3'd4; end
                ROW_CPDIS:   begin j_action = ACT_MODE; j_mode = 3'd3; end
                ROW_CPSNK:   begin j_action = ACT_MODE; j_mode = 3'd1; end
                ROW_CPSRC:   begin j_action = ACT_MODE; j_mode = 3'd2; end
                ROW_INICIAR: begin j_action = ACT_MODE; j_mode = 3'd0; end
                default:     j_action = ACT_NONE;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        avld_next    = avld_reg;
        chr_next     = chr_reg;
        slot_next    = slot_reg;
        row_next     = row_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        out_vld_next = out_vld_reg && !m_tready;
        out_next     = out_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = mac > (VW + 4)'(MAXV) ? MAXV : VW'(mac);
        ram_raddr    = (state_reg == ST_NL_RD) ? AW'(k_reg) : slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_beat)
                begin
                    chr_next = lc;
                    row_next = first_reg;
                    if (is_nl)
                    begin
                        k_next = 2'd0;
                        for (int i = 0; i < 3; i++)
                            p_next[i] = '0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_START:
                                phase_next = (is_alpha || is_blank) ? PH_WORD : PH_ERROR;
                            PH_WORD:
                            begin
                                if (c == CH_SPACE)
                                    phase_next = PH_BLANK;
                                else if (!(is_alpha || is_digit || c == CH_QUEST))
                                    phase_next = PH_ERROR;
                            end
                            PH_NUMBER:
                            begin
                                if (is_blank)
                                    phase_next = PH_BLANK;
                                else if (!is_digit)
                                    phase_next = PH_ERROR;
                                slot_next = AW'(cnt_reg - 1'b1);
                            end
                            PH_BLANK:
                            begin
                                if (is_digit)
                                begin
                                    phase_next = PH_NUMBER;
                                    if (32'(cnt_reg) < MAX_PARAMS + 1)
                                        cnt_next = cnt_reg + 1'b1;
                                end
                                else if (!is_blank)
                                    phase_next = PH_ERROR;
                                slot_next = AW'(cnt_reg);
                            end
                            default: phase_next = PH_ERROR;
                        endcase
                    end
                end
            end
            ST_SCAN_LO:
            begin
                if (tch == chr_reg)
                    first_next = row_reg;
                else if (row_s[RW:0] == last_reg)
                    row_next = first_reg;
                else
                    row_next = row_reg + 1'b1;
            end
            ST_SCAN_HI:
            begin
                if (tch != chr_reg)
                    last_next = row_s[RW:0] - 1'b1;
                else if (row_s[RW:0] != last_reg)
                    row_next = row_reg + 1'b1;
                if (tch != chr_reg || row_s[RW:0] == last_reg)
                begin
                    if (32'(pos_reg) < NAME_LENGTH)
                        pos_next = pos_reg + 1'b1;
                end
            end
            ST_DIG_RD: ;
            ST_DIG_WR:
            begin
                ram_we              = 1'b1;
                avld_next[slot_reg] = 1'b1;
            end
            ST_NL_RD: ;
            ST_NL_CAP:
            begin
                p_next[k_reg] = avld_reg[AW'(k_reg)] ? ram_rdata : '0;
                k_next        = k_reg + 2'd1;
            end
            ST_NL_OUT:
            begin
                if (!out_vld_reg)
                begin
                    out_vld_next = 1'b1;
                    out_next = {3'b000, 16'(p_reg[2]), 16'(p_reg[1]), 16'(p_reg[0]),
                                j_mode, j_action, 4'(first_reg & {RW{found}}), j_status};
                    phase_next = PH_WORD;
                    first_next = '0;
                    last_next  = LAST_ROW;
                    pos_next   = '0;
                    cnt_next   = '0;
                    avld_next  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_START;
            first_reg   <= '0;
            last_reg    <= LAST_ROW;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            avld_reg    <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
            flo_reg     <= 16'd10600;
            fhi_reg     <= 16'd11800;
            tmax_reg    <= 16'd10000;
            span_reg    <= 16'd100;
            for (int i = 0; i < 3; i++)
                p_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            avld_reg    <= avld_next;
            k_reg       <= k_next;
            out_vld_reg <= out_vld_next;
            p_reg       <= p_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FREQ_LOW:  flo_reg  <= cfg_data;
                    REG_FREQ_HIGH: fhi_reg  <= cfg_data;
                    REG_TIME_MAX:  tmax_reg <= cfg_data;
                    REG_MIN_SPAN:  span_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg  <= chr_next;
        slot_reg <= slot_next;
        row_reg  <= row_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NL_OUT && !out_vld_reg |=> out_vld_reg)
        else $error("result not loaded");
    a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_PARAMS + 1)
        else $error("parameter count overflow");
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg >= $signed({1'b0, first_reg}) - 1)
        else $error("match window broken");
    a_dig_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIG_RD |=> state_reg == ST_DIG_WR)
        else $error("digit update out of order");
`endif
endmodule

/* hw/rtl/cmdv_ram.sv */
// generic single write port ram with registered read
// no dependencies
module cmdv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* tb/cmdv_checker.sv */
// line checker for the command line parser and validator: follows character, result and
// register beats, predicts each line's verdict and compares it field by field
// depends on cmdv_pkg for the status, action, row, phase and register codes
`timescale 1ns / 1ps

module cmdv_checker
    import cmdv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [15:0] p3;
        logic [15:0] p2;
        logic [15:0] p1;
        logic [2:0]  mode;
        logic [2:0]  act;
        logic [3:0]  idx;
        logic [2:0]  status;
    } verdict_t;

    string       names [16] = '{"apagar", "barrer", "cft", "cpdis", "cpsnk", "cpsrc",
                                "estado", "frec", "frecuencia", "frecuencia?", "frec?",
                                "id?", "iniciar", "reset", "stop", "test"};
    verdict_t    verdict_q [$];
    logic [15:0] lim_lo, lim_hi, time_max, span_min;
    phase_t      phase;
    int          win_lo, win_hi, pos, nparams;
    logic [15:0] acc [3];
    int          mismatches;

    assign errors  = mismatches;

    function automatic logic [7:0] row_char(int row, int p);
        if (row < 0 || row > 15 || p >= 12 || p >= names[row].len())
            return 8'd0;
        return names[row][p];
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit in_band(logic [15:0] f);
        return f >= lim_lo && f <= lim_hi;
    endfunction

    task automatic clear_line();
        win_lo = 0;
        win_hi = 15;
        pos = 0;
        nparams = 0;
        for (int i = 0; i < 3; i++)
            acc[i] = '0;
    endtask

    task automatic narrow(logic [7:0] c);
        if (win_hi < win_lo)
            return;
        if (c >= "A" && c <= "Z")
            c = c + 8'd32;
        for (int i = win_lo; i <= win_hi; i++)
            if (row_char(i, pos) == c)
            begin
                win_lo = i;
                break;
            end
        for (int i = win_lo; i <= win_hi; i++)
            if (row_char(i, pos) != c)
            begin
                win_hi = i - 1;
                break;
            end
        if (pos < 12)
            pos++;
    endtask

    task automatic add_digit(int slot, logic [7:0] c);
        int unsigned v;
        if (slot >= 3)
            return;
        v = acc[slot] * 10 + (c - "0");
        acc[slot] = (v > 65535) ? 16'hffff : v[15:0];
    endtask

    task automatic judge_line();
        verdict_t v;
        int       need;
        v = '0;
        v.p1 = acc[0];
        v.p2 = acc[1];
        v.p3 = acc[2];
        if (!(win_hi >= win_lo && row_char(win_lo, pos) == 8'd0))
            v.status = STS_SYNTAX;
        else
        begin
            v.idx = win_lo[3:0];
            need = (win_lo == ROW_BARRER) ? 3 : (win_lo == ROW_FREC) ? 1 : 0;
            if (need > nparams)
                v.status = STS_MISSING;
            else if (need < nparams)
                v.status = STS_EXTRA;
            else
                case (win_lo)
                    ROW_BARRER:
                        if (acc[0] < 1 || acc[0] > time_max)
                            v.status = STS_TIME;
                        else if (!in_band(acc[1]) || !in_band(acc[2]))
                            v.status = STS_FREQ;
                        else if (17'(acc[1]) >= 17'(acc[2]) + 17'(span_min))
                            v.status = STS_SPAN;
                        else
                            v.act = ACT_SWEEP;
                    ROW_STOP:    v.act = ACT_STOP;
                    ROW_FREC, ROW_FRECU:
                        if (in_band(acc[0]))
                            v.act = ACT_SETF;
                        else
                            v.status = STS_FREQ;
                    ROW_FRECUQ, ROW_FRECQ: v.act = ACT_REPF;
                    ROW_IDQ:     v.act = ACT_ID;
                    ROW_ESTADO:  v.act = ACT_STATE;
                    ROW_CFT:     begin v.act = ACT_MODE; v.mode = 3'd4; end
                    ROW_CPDIS:   begin v.act = ACT_MODE; v.mode = 3'd3; end
                    ROW_CPSNK:   begin v.act = ACT_MODE; v.mode = 3'd1; end
                    ROW_CPSRC:   begin v.act = ACT_MODE; v.mode = 3'd2; end
                    ROW_INICIAR: begin v.act = ACT_MODE; v.mode = 3'd0; end
                    default: ;
                endcase
        end
        verdict_q.push_back(v);
        phase = PH_WORD;
        clear_line();
    endtask

    task automatic take_char(logic [7:0] c);
        if (c == CH_NL)
        begin
            judge_line();
            return;
        end
        case (phase)
            PH_START:
                if (is_alpha(c))
                begin
                    phase = PH_WORD;
                    narrow(c);
                end
                else if (is_blank(c))
                    phase = PH_WORD;
                else
                    phase = PH_ERROR;
            PH_WORD:
                if (c == CH_SPACE)
                    phase = PH_BLANK;
                else if (is_alpha(c) || is_digit(c) || c == CH_QUEST)
                    narrow(c);
                else
                    phase = PH_ERROR;
            PH_NUMBER:
                if (is_blank(c))
                    phase = PH_BLANK;
                else if (is_digit(c))
                    add_digit(nparams - 1, c);
                else
                    phase = PH_ERROR;
            PH_BLANK:
                if (is_digit(c))
                begin
                    add_digit(nparams, c);
                    if (nparams < 4)
                        nparams++;
                    phase = PH_NUMBER;
                end
                else if (!is_blank(c))
                    phase = PH_ERROR;
            default: phase = PH_ERROR;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got, want;
        if (!rst_n)
        begin
            lim_lo = 16'd10600;
            lim_hi = 16'd11800;
            time_max = 16'd10000;
            span_min = 16'd100;
            phase = PH_START;
            clear_line();
            verdict_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_FREQ_LOW:  lim_lo = cfg_data;
                    REG_FREQ_HIGH: lim_hi = cfg_data;
                    REG_TIME_MAX:  time_max = cfg_data;
                    REG_MIN_SPAN:  span_min = cfg_data;
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[60:0];
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got != want || m_tdata[63:61] != 3'b0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp sts %0d idx %0d act %0d mode %0d ",
                                      "p %0d %0d %0d / got sts %0d idx %0d act %0d ",
                                      "mode %0d p %0d %0d %0d"},
                                     want.status, want.idx, want.act, want.mode,
                                     want.p1, want.p2, want.p3, got.status, got.idx,
                                     got.act, got.mode, got.p1, got.p2, got.p3);
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata);
            pending = verdict_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// top of the command line parser and validator testbench: clock, reset, character and
// register stimulus, result backpressure and the verdict
// depends on cmdv_pkg, the parser block and cmdv_checker
`timescale 1ns / 1ps

module tb_top;
    import cmdv_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // char_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // status, command_index, action, mode_value,
                                  // param_first, param_second, param_third
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          errors, pending;
    int          cycles = 0;
    int          chars_sent = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_count = 0;
    logic [15:0] lo = 16'd10600, hi = 16'd11800, tmax = 16'd10000;

    string words [20] = '{"apagar", "barrer", "cft", "cpdis", "cpsnk", "cpsrc", "estado",
                          "frec", "frecuencia", "frecuencia?", "frec?", "id?", "iniciar",
                          "reset", "stop", "test", "fre", "zzz", "frecuenciax", "c"};

    command_line_parser_validator dut (.*);
    cmdv_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 800000)
        begin
            $display("** command_line_parser_validator: FAILED **");
            $finish;
        end
    end

    // result backpressure, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count > 3000)
                hold_done <= 1'b1;
        end
        else if ((cycles / 500) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_char(logic [7:0] c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1))
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CH_NL);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FREQ_LOW:  lo = val;
            REG_FREQ_HIGH: hi = val;
            REG_TIME_MAX:  tmax = val;
            default: ;
        endcase
    endtask

    function automatic string mixcase(string w);
        string r;
        r = w;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 3) == 0)
                r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string num_text();
        int unsigned v;
        case ($urandom_range(0, 7))
            0: v = lo + $urandom_range(0, 2) - 1;
            1: v = hi + $urandom_range(0, 2) - 1;
            2: v = $urandom_range(lo, hi);
            3: v = $urandom_range(0, 2);
            4: v = tmax + $urandom_range(0, 1);
            5: return "9999999";
            6: v = $urandom_range(lo, hi);
            default: v = $urandom_range(0, 65535);
        endcase
        if (v > 65535)
            v = 65535;
        return $sformatf("%0d", v);
    endfunction

    function automatic string blanks();
        return $urandom_range(0, 3) == 0 ? " \t " : " ";
    endfunction

    function automatic string random_line();
        string s;
        int    w, n;
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
        begin
            s = "";
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_NL)
                    c = CH_QUEST;
                s = {s, string'(c)};
            end
            return s;
        end
        w = $urandom_range(0, 19);
        s = mixcase(words[w]);
        n = (w == 1) ? 3 : (w == 7 || w == 8) ? 1 : 0;
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
            s = {s, blanks(), num_text()};
        if ($urandom_range(0, 9) == 0)
            s = {s, blanks()};
        if ($urandom_range(0, 14) == 0)
            s = {s, "!x 5"};
        return s;
    endfunction

    initial
    begin
        int lines;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_line("Stop");
        send_line("\tstop");
        send_line("barrer 100 10600 11800");
        send_line("BARRER 0 10600 11800");
        send_line("barrer 10001 10600 11800");
        send_line("barrer 10000 10599 11800");
        send_line("barrer 1 11000 10900");
        send_line("barrer 1 11000 10901");
        send_line("barrer 1 2");
        send_line("barrer 1 2 3 4 5");
        send_line("frec 11800");
        send_line("frecuencia 11801");
        send_line("frec 9999999");
        send_line("frecuencia?");
        send_line("frec?");
        send_line("id?");
        send_line("estado");
        send_line("cft");
        send_line("cpdis");
        send_line("cpsnk");
        send_line("cpsrc");
        send_line("iniciar\t");
        send_line("apagar x");
        send_line("zzzq");
        send_line({"frec 11", string'(8'd200), "00"});
        write_reg(REG_FREQ_LOW, 16'd0);
        write_reg(REG_FREQ_HIGH, 16'd65535);
        write_reg(REG_TIME_MAX, 16'd65535);
        write_reg(REG_MIN_SPAN, 16'd0);
        send_line("barrer 65535 0 65535");
        send_line("frec 0");
        lines = 0;
        while (chars_sent < 1450)
        begin
            if (lines % 25 == 24)
            begin
                write_reg(REG_FREQ_LOW, $urandom_range(0, 3) == 0 ? 16'd0
                          : 16'($urandom_range(9000, 11000)));
                write_reg(REG_FREQ_HIGH, $urandom_range(0, 3) == 0 ? 16'd65535
                          : 16'($urandom_range(lo, 13000)));
                write_reg(REG_TIME_MAX, $urandom_range(0, 3) == 0 ? 16'd1
                          : 16'($urandom_range(1, 20000)));
                write_reg(REG_MIN_SPAN, $urandom_range(0, 3) == 0 ? 16'd65535
                          : 16'($urandom_range(0, 500)));
            end
            if (lines == 40)
                hold_req = 1'b1;
            send_line(random_line());
            lines++;
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("** command_line_parser_validator: PASSED **");
        else
            $display("** command_line_parser_validator: FAILED **");
        $finish;
    end

endmodule
